@@ rtl/pjcf_pkg.sv @@
// ----------------------------------------------------------------------------
// pjcf_pkg
// Shared types, constants and helpers of the position jump confirm filter.
// ----------------------------------------------------------------------------
package pjcf_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CFG_W       = 15;
    localparam int COUNT_W     = 8;
    localparam int IDX_W       = 2;

    // squares and their three-term sum
    localparam int SQ_W    = 2 * COORD_WIDTH;
    localparam int SUM_W   = SQ_W + 2;
    localparam int THR_W   = 2 * CFG_W;
    localparam int WIDE_W  = (SUM_W > THR_W) ? SUM_W : THR_W;
    localparam int TOL_W   = (COORD_WIDTH > CFG_W) ? COORD_WIDTH : CFG_W;

    localparam logic [CFG_W-1:0]   CHANGE_TOL_RST = CFG_W'(10);
    localparam logic [CFG_W-1:0]   JUMP_THR_RST   = CFG_W'(500);
    localparam logic [CFG_W-1:0]   CAND_TOL_RST   = CFG_W'(200);
    localparam logic [COUNT_W-1:0] CONFIRM_RST    = COUNT_W'(3);

    typedef enum logic [IDX_W-1:0] {
        REG_CHANGE_TOL = 2'd0,
        REG_JUMP_THR   = 2'd1,
        REG_CAND_TOL   = 2'd2,
        REG_CONFIRM    = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_UNCHANGED  = 2'd0,
        ST_NEW_CAND   = 2'd1,
        ST_CONFIRMING = 2'd2,
        ST_ACCEPTED   = 2'd3
    } status_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic signed [COORD_WIDTH-1:0] z;
    } pose_t;

    typedef struct packed {
        logic [CFG_W-1:0]   change_tol;
        logic [CFG_W-1:0]   jump_thr;
        logic [CFG_W-1:0]   cand_tol;
        logic [COUNT_W-1:0] confirm_need;
    } cfg_t;

    // magnitude of a - b; always fits in COORD_WIDTH unsigned bits
    function automatic logic [COORD_WIDTH-1:0] abs_diff(
        input logic signed [COORD_WIDTH-1:0] a,
        input logic signed [COORD_WIDTH-1:0] b
    );
        logic signed [COORD_WIDTH:0] d;
        logic signed [COORD_WIDTH:0] n;
        d = {a[COORD_WIDTH-1], a} - {b[COORD_WIDTH-1], b};
        n = -d;
        return d[COORD_WIDTH] ? n[COORD_WIDTH-1:0] : d[COORD_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/pjcf_cfg.sv @@
// ----------------------------------------------------------------------------
// pjcf_cfg
// Configuration register file, write-only, loaded by index.
// ----------------------------------------------------------------------------
module pjcf_cfg
    import pjcf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CHANGE_TOL: cfg_next.change_tol   = cfg_data;
                REG_JUMP_THR:   cfg_next.jump_thr     = cfg_data;
                REG_CAND_TOL:   cfg_next.cand_tol     = cfg_data;
                REG_CONFIRM:    cfg_next.confirm_need = cfg_data[COUNT_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.change_tol   <= CHANGE_TOL_RST;
            cfg_reg.jump_thr     <= JUMP_THR_RST;
            cfg_reg.cand_tol     <= CAND_TOL_RST;
            cfg_reg.confirm_need <= CONFIRM_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ rtl/pjcf_dist.sv @@
// ----------------------------------------------------------------------------
// pjcf_dist
// Squared Euclidean distance between two poses.
// ----------------------------------------------------------------------------
module pjcf_dist
    import pjcf_pkg::*;
(
    input  pose_t            a,
    input  pose_t            b,
    output logic [SUM_W-1:0] dist_sq
);

    logic [COORD_WIDTH-1:0] dx;
    logic [COORD_WIDTH-1:0] dy;
    logic [COORD_WIDTH-1:0] dz;
    logic [SQ_W-1:0]        sx;
    logic [SQ_W-1:0]        sy;
    logic [SQ_W-1:0]        sz;

    assign dx = abs_diff(a.x, b.x);
    assign dy = abs_diff(a.y, b.y);
    assign dz = abs_diff(a.z, b.z);

    assign sx = SQ_W'(dx) * SQ_W'(dx);
    assign sy = SQ_W'(dy) * SQ_W'(dy);
    assign sz = SQ_W'(dz) * SQ_W'(dz);

    assign dist_sq = SUM_W'(sx) + SUM_W'(sy) + SUM_W'(sz);

endmodule

@@ rtl/position_jump_confirm_filter_top.sv @@
// ----------------------------------------------------------------------------
// position_jump_confirm_filter_top
// Path: the input word register loads at the accept edge, the result
// register when the held word advances; the decision and both squared
// distances sit between. Throughput: one word per cycle while the result
// side does not stall; pose and count state update as the word advances.
// Reset: asynchronous, active low; poses and count clear to zero, registers
// return to their defaults, both channels empty.
// ----------------------------------------------------------------------------
module position_jump_confirm_filter_top
    import pjcf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [IDX_W-1:0]              cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [COORD_WIDTH-1:0] pos_x,
    input  logic signed [COORD_WIDTH-1:0] pos_y,
    input  logic signed [COORD_WIDTH-1:0] pos_z,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          accepted,
    output logic [1:0]                    status,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic [COUNT_W-1:0]            confirm_count
);

    cfg_t cfg;

    pjcf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input word register
    logic  s1_valid_reg, s1_valid_next;
    pose_t s1_pose_reg;
    logic  in_take;
    logic  s1_adv;

    // filter state
    pose_t              last_reg, last_next;
    pose_t              pend_reg, pend_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic               acc_reg, acc_next;
    status_t            status_reg, status_next;
    pose_t              opose_reg;
    logic [COUNT_W-1:0] ocount_reg;

    assign s1_adv   = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
            s1_valid_next = 1'b1;
        else if (s1_adv)
            s1_valid_next = 1'b0;
    end

    // distances of the held word from the accepted and the pending pose
    logic [SUM_W-1:0] dsq_last;
    logic [SUM_W-1:0] dsq_pend;

    pjcf_dist u_dist_last (
        .a       (s1_pose_reg),
        .b       (last_reg),
        .dist_sq (dsq_last)
    );

    pjcf_dist u_dist_pend (
        .a       (s1_pose_reg),
        .b       (pend_reg),
        .dist_sq (dsq_pend)
    );

    logic               changed;
    logic               big_jump;
    logic               far_cand;
    logic [WIDE_W-1:0]  jt_sq;
    logic [WIDE_W-1:0]  ct_sq;
    logic [COUNT_W-1:0] count_inc;
    logic [TOL_W-1:0]   tol;

    assign tol     = TOL_W'(cfg.change_tol);
    assign changed = (TOL_W'(abs_diff(s1_pose_reg.x, last_reg.x)) > tol)
                  || (TOL_W'(abs_diff(s1_pose_reg.y, last_reg.y)) > tol)
                  || (TOL_W'(abs_diff(s1_pose_reg.z, last_reg.z)) > tol);

    assign jt_sq    = WIDE_W'(cfg.jump_thr) * WIDE_W'(cfg.jump_thr);
    assign ct_sq    = WIDE_W'(cfg.cand_tol) * WIDE_W'(cfg.cand_tol);
    assign big_jump = WIDE_W'(dsq_last) > jt_sq;
    assign far_cand = WIDE_W'(dsq_pend) > ct_sq;

    // saturate the confirmation count
    assign count_inc = (count_reg == {COUNT_W{1'b1}}) ? count_reg
                                                      : count_reg + 1'b1;

    always_comb
    begin
        last_next   = last_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        acc_next    = 1'b0;
        status_next = ST_UNCHANGED;
        if (changed)
        begin
            if (big_jump && far_cand)
            begin
                // restart on a new candidate
                pend_next   = s1_pose_reg;
                count_next  = COUNT_W'(1);
                status_next = ST_NEW_CAND;
            end
            else if (big_jump && (count_inc < cfg.confirm_need))
            begin
                count_next  = count_inc;
                status_next = ST_CONFIRMING;
            end
            else
            begin
                last_next   = s1_pose_reg;
                pend_next   = s1_pose_reg;
                count_next  = '0;
                acc_next    = 1'b1;
                status_next = ST_ACCEPTED;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (s1_adv)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= '0;
            pend_reg      <= '0;
            count_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (s1_adv)
            begin
                last_reg  <= last_next;
                pend_reg  <= pend_next;
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_pose_reg.x <= pos_x;
            s1_pose_reg.y <= pos_y;
            s1_pose_reg.z <= pos_z;
        end
        if (s1_adv)
        begin
            acc_reg    <= acc_next;
            status_reg <= status_next;
            opose_reg  <= last_next;
            ocount_reg <= count_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign accepted      = acc_reg;
    assign status        = status_reg;
    assign out_x         = opose_reg.x;
    assign out_y         = opose_reg.y;
    assign out_z         = opose_reg.z;
    assign confirm_count = ocount_reg;

    // the shown pose always tracks the accepted state
    a_pose_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (opose_reg == last_reg))
        else $error("result pose differs from accepted state");

    a_accept_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && accepted) |-> (confirm_count == '0 && status == ST_ACCEPTED))
        else $error("accepted word with count not cleared");

    a_new_cand_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_NEW_CAND) |-> (confirm_count == COUNT_W'(1)))
        else $error("new candidate without count of one");

    a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled with no word held");

    a_unchanged_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && !changed) |=> (last_reg == $past(last_reg)
                                  && count_reg == $past(count_reg)))
        else $error("unchanged word altered state");

endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the position jump confirm filter. A scripted run
// covers the tolerance and threshold edges, the coordinate extremes,
// candidate restarts and a requirement change in the middle of a
// confirmation run. Randomized phases under several register settings
// follow. Every result word is checked against a built-in filter predictor
// or a typed row's own expectation while both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top
    import pjcf_pkg::*;
();

    localparam int C_MAX = 2 ** (COORD_WIDTH - 1) - 1;
    localparam int C_MIN = -(2 ** (COORD_WIDTH - 1));

    typedef struct {
        logic               acc;
        status_t            st;
        pose_t              pose;
        logic [COUNT_W-1:0] cnt;
    } filter_report_t;

    typedef struct {
        pose_t          p;
        bit             typed;
        filter_report_t want;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic [IDX_W-1:0]              cfg_index = '0;
    logic [CFG_W-1:0]              cfg_data = '0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [COORD_WIDTH-1:0] pos_x = '0;
    logic signed [COORD_WIDTH-1:0] pos_y = '0;
    logic signed [COORD_WIDTH-1:0] pos_z = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          accepted;
    logic [1:0]                    status;
    logic signed [COORD_WIDTH-1:0] out_x;
    logic signed [COORD_WIDTH-1:0] out_y;
    logic signed [COORD_WIDTH-1:0] out_z;
    logic [COUNT_W-1:0]            confirm_count;

    position_jump_confirm_filter_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .accepted     (accepted),
        .status       (status),
        .out_x        (out_x),
        .out_y        (out_y),
        .out_z        (out_z),
        .confirm_count(confirm_count)
    );

    always #10 clk = ~clk;

    // predictor state and register copy
    pose_t held_pose;
    pose_t cand_pose;
    int    confirm_run;
    int    tol_change;
    int    thr_jump;
    int    tol_cand;
    int    need_confirm;

    filter_report_t pose_reports_due[$];
    stim_row_t      script_rows[$];
    int             errors = 0;
    int             send_gap_pct = 0;
    int             stall_pct = 0;
    int             stall_left = 0;

    function automatic int pause_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(8, 40);
        return $urandom_range(1, 3);
    endfunction

    function automatic pose_t mk_pose(input int x, input int y, input int z);
        pose_t r;
        r.x = COORD_WIDTH'(x);
        r.y = COORD_WIDTH'(y);
        r.z = COORD_WIDTH'(z);
        return r;
    endfunction

    function automatic int clamp_coord(input int v);
        if (v > C_MAX)
            return C_MAX;
        if (v < C_MIN)
            return C_MIN;
        return v;
    endfunction

    function automatic int jitter(input int r);
        return int'($urandom_range(0, 2 * r)) - r;
    endfunction

    function automatic pose_t near(input pose_t base, input int r);
        return mk_pose(clamp_coord(int'(base.x) + jitter(r)),
                       clamp_coord(int'(base.y) + jitter(r)),
                       clamp_coord(int'(base.z) + jitter(r)));
    endfunction

    function automatic int axis_gap(input logic signed [COORD_WIDTH-1:0] a,
                                    input logic signed [COORD_WIDTH-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return (d < 0) ? -d : d;
    endfunction

    function automatic longint sq_dist(input pose_t a, input pose_t b);
        longint dx;
        longint dy;
        longint dz;
        dx = axis_gap(a.x, b.x);
        dy = axis_gap(a.y, b.y);
        dz = axis_gap(a.z, b.z);
        return dx * dx + dy * dy + dz * dz;
    endfunction

    // advance the filter state by one sample and return its report
    function automatic filter_report_t filter_sample(input pose_t p);
        filter_report_t r;
        logic           moved;
        logic           take;
        moved = (axis_gap(p.x, held_pose.x) > tol_change) ||
                (axis_gap(p.y, held_pose.y) > tol_change) ||
                (axis_gap(p.z, held_pose.z) > tol_change);
        r.acc = 1'b0;
        r.st  = ST_UNCHANGED;
        if (moved)
        begin
            take = 1'b1;
            if (sq_dist(p, held_pose) > longint'(thr_jump) * thr_jump)
            begin
                if (sq_dist(p, cand_pose) > longint'(tol_cand) * tol_cand)
                begin
                    // far from the candidate: restart the run here
                    cand_pose   = p;
                    confirm_run = 1;
                    r.st        = ST_NEW_CAND;
                    take        = 1'b0;
                end
                else
                begin
                    if (confirm_run < 255)
                        confirm_run++;
                    if (confirm_run < need_confirm)
                    begin
                        r.st = ST_CONFIRMING;
                        take = 1'b0;
                    end
                end
            end
            if (take)
            begin
                held_pose   = p;
                cand_pose   = p;
                confirm_run = 0;
                r.acc       = 1'b1;
                r.st        = ST_ACCEPTED;
            end
        end
        r.pose = held_pose;
        r.cnt  = COUNT_W'(confirm_run);
        return r;
    endfunction

    function automatic stim_row_t row(input int x, input int y, input int z);
        stim_row_t s;
        s.p     = mk_pose(x, y, z);
        s.typed = 1'b0;
        return s;
    endfunction

    function automatic stim_row_t row_typed(input int x, input int y, input int z,
                                            input logic acc, input status_t st,
                                            input int ox, input int oy, input int oz,
                                            input int cnt);
        stim_row_t s;
        s.p         = mk_pose(x, y, z);
        s.typed     = 1'b1;
        s.want.acc  = acc;
        s.want.st   = st;
        s.want.pose = mk_pose(ox, oy, oz);
        s.want.cnt  = COUNT_W'(cnt);
        return s;
    endfunction

    // append one row to the stimulus table
    function automatic void add_row(input stim_row_t s);
        script_rows.insert(script_rows.size(), s);
    endfunction

    // present one word, hold it until taken, then maybe idle
    task automatic send_sample(input pose_t p, input bit typed,
                               input filter_report_t want);
        filter_report_t rep;
        rep = filter_sample(p);
        if (typed)
            rep = want;
        pose_reports_due.insert(pose_reports_due.size(), rep);
        in_valid <= 1'b1;
        pos_x    <= p.x;
        pos_y    <= p.y;
        pos_z    <= p.z;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            repeat (pause_len()) @(posedge clk);
        end
    endtask

    task automatic offer(input pose_t p);
        filter_report_t none;
        none.acc  = 1'b0;
        none.st   = ST_UNCHANGED;
        none.pose = '0;
        none.cnt  = '0;
        send_sample(p, 1'b0, none);
    endtask

    // hold off the sender until every result word is back
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (pose_reports_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(input int ct, input int jt, input int cand,
                                 input int need);
        cfg_we    <= 1'b1;
        cfg_index <= REG_CHANGE_TOL;
        cfg_data  <= CFG_W'(ct);
        @(posedge clk);
        cfg_index <= REG_JUMP_THR;
        cfg_data  <= CFG_W'(jt);
        @(posedge clk);
        cfg_index <= REG_CAND_TOL;
        cfg_data  <= CFG_W'(cand);
        @(posedge clk);
        cfg_index <= REG_CONFIRM;
        cfg_data  <= CFG_W'(need & 8'hFF);
        @(posedge clk);
        cfg_we       <= 1'b0;
        tol_change   = ct & 16'h7FFF;
        thr_jump     = jt & 16'h7FFF;
        tol_cand     = cand & 16'h7FFF;
        need_confirm = need & 8'hFF;
        @(posedge clk);
    endtask

    task automatic run_phase(input int n);
        int    done;
        int    kind;
        int    k;
        int    k_cap;
        pose_t target;
        done = 0;
        while (done < n)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 15)
            begin
                offer(near(held_pose, tol_change));
                done++;
            end
            else if (kind < 35)
            begin
                offer(near(held_pose, thr_jump / 2));
                done++;
            end
            else if (kind < 80)
            begin
                // jump, then a run of samples close to it
                if ($urandom_range(0, 1) == 0)
                    target = mk_pose($urandom, $urandom, $urandom);
                else
                    target = near(held_pose, thr_jump + 1 + $urandom_range(0, 2000));
                offer(target);
                done++;
                k_cap = need_confirm + 1;
                if (k_cap > 9 && $urandom_range(0, 49) != 0)
                    k_cap = 8;
                k = ($urandom_range(0, 9) == 0) ? k_cap : $urandom_range(0, k_cap);
                repeat (k)
                begin
                    offer(near(target, tol_cand / 2));
                    done++;
                end
            end
            else if (kind < 88)
            begin
                offer(near(cand_pose, 2 * tol_cand + 50));
                done++;
            end
            else
            begin
                offer(mk_pose($urandom, $urandom, $urandom));
                done++;
            end
        end
    endtask

    // result side: random stall
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end
        else if ($urandom_range(0, 99) < stall_pct)
        begin
            stall_left <= pause_len() - 1;
            out_stall  <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin : check_reports
        filter_report_t rep;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pose_reports_due.size() == 0)
            begin
                $error("result word with no expectation pending");
                errors++;
            end
            else
            begin
                rep = pose_reports_due.pop_front();
                if (accepted !== rep.acc)
                begin
                    $error("accepted mismatch: expected %0d, actual %0d", rep.acc, accepted);
                    errors++;
                end
                if (status !== rep.st)
                begin
                    $error("status mismatch: expected %0d, actual %0d", rep.st, status);
                    errors++;
                end
                if (out_x !== rep.pose.x)
                begin
                    $error("out_x mismatch: expected %0d, actual %0d", rep.pose.x, out_x);
                    errors++;
                end
                if (out_y !== rep.pose.y)
                begin
                    $error("out_y mismatch: expected %0d, actual %0d", rep.pose.y, out_y);
                    errors++;
                end
                if (out_z !== rep.pose.z)
                begin
                    $error("out_z mismatch: expected %0d, actual %0d", rep.pose.z, out_z);
                    errors++;
                end
                if (confirm_count !== rep.cnt)
                begin
                    $error("confirm_count mismatch: expected %0d, actual %0d",
                           rep.cnt, confirm_count);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        pose_t jump_pt;
        held_pose    = '0;
        cand_pose    = '0;
        confirm_run  = 0;
        tol_change   = CHANGE_TOL_RST;
        thr_jump     = JUMP_THR_RST;
        tol_cand     = CAND_TOL_RST;
        need_confirm = CONFIRM_RST;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // scripted part under the reset settings
        add_row(row_typed(0, 0, 0, 1'b0, ST_UNCHANGED, 0, 0, 0, 0));
        add_row(row_typed(10, -10, 10, 1'b0, ST_UNCHANGED, 0, 0, 0, 0));
        add_row(row_typed(11, 0, 0, 1'b1, ST_ACCEPTED, 11, 0, 0, 0));
        // distance exactly at the jump threshold
        add_row(row_typed(311, 400, 0, 1'b1, ST_ACCEPTED, 311, 400, 0, 0));
        add_row(row(C_MAX, C_MAX, C_MAX));
        add_row(row(C_MAX, C_MAX, C_MAX));
        // confirm exactly at the candidate tolerance
        add_row(row(C_MAX - 200, C_MAX, C_MAX));
        add_row(row(C_MIN, C_MIN, C_MIN));
        // just outside the candidate tolerance: restart the run
        add_row(row(C_MIN, C_MIN, C_MIN + 201));
        add_row(row(C_MIN, C_MIN, C_MIN + 201));
        // unchanged while a run is open
        add_row(row(C_MAX - 195, C_MAX - 3, C_MAX));
        add_row(row(-32700, C_MIN, C_MIN + 201));
        add_row(row(-32000, C_MIN, C_MIN + 201));
        // small change drops the open run
        add_row(row(-32400, C_MIN, C_MIN + 201));
        add_row(row(C_MAX, C_MIN, C_MAX));
        add_row(row(-1, -1, -1));
        add_row(row(C_MIN, C_MAX, C_MIN));
        add_row(row(21845, -21846, 21845));

        send_gap_pct = 30;
        stall_pct    = 30;
        foreach (script_rows[i])
            send_sample(script_rows[i].p, script_rows[i].typed, script_rows[i].want);
        drain_reports();

        // lower the requirement in the middle of a run
        load_settings(10, 500, 200, 255);
        jump_pt = mk_pose(1000, 1000, 1000);
        repeat (5) offer(jump_pt);
        drain_reports();
        load_settings(10, 500, 200, 3);
        offer(jump_pt);
        drain_reports();

        send_gap_pct = 25;
        stall_pct    = 25;
        load_settings(0, 0, 0, 0);
        run_phase(130);
        drain_reports();

        load_settings(32767, 32767, 32767, 255);
        run_phase(130);
        drain_reports();

        // a stretch with no idling on either side
        send_gap_pct = 0;
        stall_pct    = 0;
        load_settings(10, 500, 200, 3);
        run_phase(130);
        drain_reports();

        send_gap_pct = 50;
        stall_pct    = 50;
        load_settings(3, 150, 60, 1);
        run_phase(130);
        drain_reports();

        send_gap_pct = 20;
        stall_pct    = 35;
        load_settings(0, 1000, 0, 2);
        run_phase(130);
        drain_reports();

        repeat (3)
        begin
            send_gap_pct = $urandom_range(0, 60);
            stall_pct    = $urandom_range(0, 60);
            load_settings($urandom_range(0, 40), $urandom_range(0, 3000),
                          $urandom_range(0, 600), $urandom_range(0, 10));
            run_phase(130);
            drain_reports();
        end

        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
